// ----- sv/mtep_pkg.sv -----
// types and constants shared by the track event parser modules
package mtep_pkg;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int DELTA_W = 28;
   localparam int TEMPO_W = 24;
   localparam int SKIP_W  = 28;

   localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
   localparam logic [7:0] STATUS_META      = 8'hFF;
   localparam logic [7:0] META_TEMPO       = 8'h51;
   localparam logic [7:0] META_END         = 8'h2F;
   localparam logic [3:0] VOICE_NOTE_OFF   = 4'h8;
   localparam logic [3:0] VOICE_NOTE_ON    = 4'h9;
   // program change and channel pressure carry one data byte
   localparam logic [2:0] VOICE_ONE_BYTE   = 3'b110;

   typedef enum logic [2:0] {
      CLS_DATA,
      CLS_VOICE,
      CLS_META,
      CLS_SYSEX,
      CLS_SYSTEM
   } byte_class_type;

   typedef enum logic [3:0] {
      PH_DELTA,
      PH_STATUS,
      PH_DATA1,
      PH_DATA2,
      PH_MTYPE,
      PH_LEN,
      PH_BODY
   } parse_phase_type;

   typedef enum logic [2:0] {
      KIND_NOTE_OFF,
      KIND_NOTE_ON,
      KIND_VOICE,
      KIND_TEMPO,
      KIND_END,
      KIND_ERROR
   } event_kind_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           track_start;
      byte_class_type byte_class;
   } queue_entry_type;

endpackage

// ----- sv/mtep_front.sv -----
// input side: takes words, classifies the byte and queues it for the parser
module mtep_front
   import mtep_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_data_byte,
   input  logic            req_track_start,
   output logic            q_valid,
   output queue_entry_type q_entry,
   input  logic            q_pop
);

   queue_entry_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]     wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0]   count_ff;
   logic [QUEUE_COUNT_W-1:0]   count_in;
   logic                       push;
   logic                       pop;
   queue_entry_type            new_entry;
   byte_class_type             new_class;

   always_comb begin
      case (req_data_byte) inside
         [8'h00:8'h7F]:                   new_class = CLS_DATA;
         [8'h80:8'hEF]:                   new_class = CLS_VOICE;
         STATUS_META:                     new_class = CLS_META;
         STATUS_SYSEX, STATUS_SYSEX_END:  new_class = CLS_SYSEX;
         default:                         new_class = CLS_SYSTEM;
      endcase
   end

   assign new_entry.data_byte   = req_data_byte;
   assign new_entry.track_start = req_track_start;
   assign new_entry.byte_class  = new_class;

   assign req_stall = (count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   assign wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_COUNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_COUNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ----- sv/mtep_back.sv -----
// parser side: runs the event state machine on queued bytes, holds the result word
module mtep_back
   import mtep_pkg::*;
#(
   parameter int MAX_VLQ_BYTES = 4
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  queue_entry_type     q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_event_kind,
   output logic [3:0]          rsp_channel,
   output logic [6:0]          rsp_key,
   output logic [6:0]          rsp_velocity,
   output logic [DELTA_W-1:0]  rsp_delta_ticks,
   output logic [TEMPO_W-1:0]  rsp_tempo_us
);

   localparam int VLQ_CNT_W = $clog2(MAX_VLQ_BYTES + 1);

   parse_phase_type       phase_ff, phase_in, cur_phase;
   logic [7:0]            rs_ff, rs_in, cur_rs;
   logic [DELTA_W-1:0]    delta_ff, delta_in, cur_delta;
   logic [VLQ_CNT_W-1:0]  cnt_ff, cnt_in, cur_cnt;
   logic [6:0]            first_ff, first_in, cur_first;
   logic [7:0]            mt_ff, mt_in, cur_mt;
   logic [SKIP_W-1:0]     skip_ff, skip_in, cur_skip;
   logic [TEMPO_W-1:0]    tempo_ff, tempo_in, cur_tempo;
   logic                  ended_ff, ended_in, cur_ended;

   logic                  rsp_valid_ff, rsp_valid_in;
   event_kind_type        kind_ff;
   logic [3:0]            channel_ff;
   logic [6:0]            key_ff;
   logic [6:0]            velocity_ff;
   logic [DELTA_W-1:0]    rsp_delta_ff;
   logic [TEMPO_W-1:0]    rsp_tempo_ff;

   logic                  pop;
   logic                  strt;
   logic                  go;
   logic [7:0]            b;
   logic                  cont;
   logic [VLQ_CNT_W-1:0]  cnt_inc;
   logic                  vlq_over;
   logic [SKIP_W-1:0]     skip_shift;
   logic [SKIP_W-1:0]     skip_dec;
   logic                  one_byte;

   logic                  res_fire;
   event_kind_type        res_kind;
   logic [3:0]            res_channel;
   logic [6:0]            res_key;
   logic [6:0]            res_vel;
   logic [DELTA_W-1:0]    res_delta;
   logic [TEMPO_W-1:0]    res_tempo;

   assign pop   = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = pop;
   assign strt  = pop && q_entry.track_start;
   assign b     = q_entry.data_byte;
   assign cont  = b[7];

   // a new track clears everything before its first byte is parsed
   assign cur_phase = strt ? PH_DELTA : phase_ff;
   assign cur_rs    = strt ? '0 : rs_ff;
   assign cur_delta = strt ? '0 : delta_ff;
   assign cur_cnt   = strt ? '0 : cnt_ff;
   assign cur_first = strt ? '0 : first_ff;
   assign cur_mt    = strt ? '0 : mt_ff;
   assign cur_skip  = strt ? '0 : skip_ff;
   assign cur_tempo = strt ? '0 : tempo_ff;
   assign cur_ended = strt ? 1'b0 : ended_ff;

   assign go         = pop && !cur_ended;
   assign cnt_inc    = cur_cnt + VLQ_CNT_W'(1);
   assign vlq_over   = (cnt_inc >= VLQ_CNT_W'(MAX_VLQ_BYTES));
   assign skip_shift = {cur_skip[SKIP_W-8:0], b[6:0]};
   assign skip_dec   = (cur_skip != '0) ? cur_skip - SKIP_W'(1) : cur_skip;
   assign one_byte   = (cur_rs[7:5] == VOICE_ONE_BYTE);

   // next state
   always_comb begin
      phase_in = cur_phase;
      if (go) begin
         case (cur_phase)
            PH_DELTA: begin
               phase_in = cont ? PH_DELTA : PH_STATUS;
            end
            PH_STATUS: begin
               case (q_entry.byte_class)
                  CLS_DATA: begin
                     if (cur_rs == '0 || one_byte) begin
                        phase_in = PH_DELTA;
                     end else begin
                        phase_in = PH_DATA2;
                     end
                  end
                  CLS_VOICE: phase_in = PH_DATA1;
                  CLS_META:  phase_in = PH_MTYPE;
                  CLS_SYSEX: phase_in = PH_LEN;
                  default:   phase_in = PH_DELTA;
               endcase
            end
            PH_DATA1: phase_in = one_byte ? PH_DELTA : PH_DATA2;
            PH_DATA2: phase_in = PH_DELTA;
            PH_MTYPE: phase_in = PH_LEN;
            PH_LEN: begin
               if (!cont) begin
                  phase_in = (skip_shift == '0) ? PH_DELTA : PH_BODY;
               end else begin
                  phase_in = vlq_over ? PH_DELTA : PH_LEN;
               end
            end
            PH_BODY: phase_in = (skip_dec == '0) ? PH_DELTA : PH_BODY;
            default: phase_in = PH_DELTA;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      rs_in       = cur_rs;
      delta_in    = cur_delta;
      cnt_in      = cur_cnt;
      first_in    = cur_first;
      mt_in       = cur_mt;
      skip_in     = cur_skip;
      tempo_in    = cur_tempo;
      ended_in    = cur_ended;
      res_fire    = 1'b0;
      res_kind    = KIND_ERROR;
      res_channel = '0;
      res_key     = '0;
      res_vel     = '0;
      res_delta   = '0;
      res_tempo   = '0;
      if (go) begin
         case (cur_phase)
            PH_DELTA: begin
               delta_in = {cur_delta[DELTA_W-8:0], b[6:0]};
               cnt_in   = cnt_inc;
               if (!cont) begin
                  cnt_in = '0;
               end else if (vlq_over) begin
                  res_fire = 1'b1;
               end
            end
            PH_STATUS: begin
               case (q_entry.byte_class)
                  CLS_DATA: begin
                     if (cur_rs == '0) begin
                        res_fire = 1'b1;
                     end else begin
                        first_in = b[6:0];
                        if (one_byte) begin
                           res_fire = 1'b1;
                           res_kind = KIND_VOICE;
                        end
                     end
                  end
                  CLS_VOICE: rs_in = b;
                  CLS_META:  rs_in = '0;
                  CLS_SYSEX: begin
                     rs_in   = '0;
                     mt_in   = b;
                     skip_in = '0;
                     cnt_in  = '0;
                  end
                  default: res_fire = 1'b1;
               endcase
            end
            PH_DATA1: begin
               first_in = b[6:0];
               if (one_byte) begin
                  res_fire = 1'b1;
                  res_kind = KIND_VOICE;
               end
            end
            PH_DATA2: begin
               res_fire = 1'b1;
               res_vel  = b[6:0];
               if (cur_rs[7:4] == VOICE_NOTE_OFF) begin
                  res_kind = KIND_NOTE_OFF;
               end else if (cur_rs[7:4] == VOICE_NOTE_ON) begin
                  res_kind = (b[6:0] == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
               end else begin
                  res_kind = KIND_VOICE;
               end
            end
            PH_MTYPE: begin
               mt_in    = b;
               skip_in  = '0;
               cnt_in   = '0;
               tempo_in = '0;
            end
            PH_LEN: begin
               skip_in = skip_shift;
               cnt_in  = cnt_inc;
               if (!cont) begin
                  cnt_in = '0;
               end else if (vlq_over) begin
                  res_fire = 1'b1;
               end
            end
            PH_BODY: begin
               if (cur_mt == META_TEMPO) begin
                  tempo_in = {cur_tempo[TEMPO_W-9:0], b};
               end
               skip_in = skip_dec;
            end
            default: ;
         endcase

         // end of a meta or sysex body
         if ((cur_phase == PH_LEN && !cont && skip_shift == '0) ||
             (cur_phase == PH_BODY && skip_dec == '0)) begin
            if (cur_mt == META_TEMPO) begin
               res_fire  = 1'b1;
               res_kind  = KIND_TEMPO;
               res_tempo = tempo_in;
            end else if (cur_mt == META_END) begin
               res_fire = 1'b1;
               res_kind = KIND_END;
               ended_in = 1'b1;
            end else begin
               delta_in = '0;
               cnt_in   = '0;
            end
         end

         if (res_fire) begin
            if (res_kind != KIND_ERROR) begin
               res_delta = cur_delta;
            end
            if (res_kind == KIND_NOTE_OFF || res_kind == KIND_NOTE_ON ||
                res_kind == KIND_VOICE) begin
               res_channel = cur_rs[3:0];
               res_key     = first_in;
            end
            delta_in = '0;
            cnt_in   = '0;
         end
      end
   end

   assign rsp_valid_in = (pop && res_fire) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DELTA;
         rs_ff        <= '0;
         delta_ff     <= '0;
         cnt_ff       <= '0;
         first_ff     <= '0;
         mt_ff        <= '0;
         skip_ff      <= '0;
         tempo_ff     <= '0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            rs_ff    <= rs_in;
            delta_ff <= delta_in;
            cnt_ff   <= cnt_in;
            first_ff <= first_in;
            mt_ff    <= mt_in;
            skip_ff  <= skip_in;
            tempo_ff <= tempo_in;
            ended_ff <= ended_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && res_fire) begin
         kind_ff      <= res_kind;
         channel_ff   <= res_channel;
         key_ff       <= res_key;
         velocity_ff  <= res_vel;
         rsp_delta_ff <= res_delta;
         rsp_tempo_ff <= res_tempo;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_channel     = channel_ff;
   assign rsp_key         = key_ff;
   assign rsp_velocity    = velocity_ff;
   assign rsp_delta_ticks = rsp_delta_ff;
   assign rsp_tempo_us    = rsp_tempo_ff;

`ifndef SYNTHESIS
   a_end_sets_ended: assert property (@(posedge clock) disable iff (reset)
      (pop && res_fire && res_kind == KIND_END) |=> ended_ff)
      else $error("end of track did not mark the track ended");

   a_ended_holds: assert property (@(posedge clock) disable iff (reset)
      (ended_ff && pop && !q_entry.track_start) |=> (phase_ff == $past(phase_ff)))
      else $error("parser state moved after end of track");

   a_vlq_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < VLQ_CNT_W'(MAX_VLQ_BYTES))
      else $error("length byte count passed its limit");

   a_body_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (skip_ff != '0))
      else $error("body phase with nothing left to skip");
`endif

endmodule

// ----- sv/midi_track_event_parser.sv -----
// Track event parser for standard MIDI file track data, one byte per input word. It decodes
// delta times, running status, note on/off (velocity zero counts as note off), other voice
// messages, and skips sysex and meta bodies by their length, reporting set-tempo and
// end-of-track; bytes after end-of-track are dropped until a word flagged track_start.
// Sustained rate is one byte per cycle while the output is not stalled: each byte is one
// pass of the combinational parser step, and a four-word queue sits between the input and
// the parser. The byte completing an event is written into the queue, popped into the
// parser step, and its result is registered in the result word. While a result word waits
// on rsp_stall the parser holds, the queue fills and req_stall rises. A delta or length of
// MAX_VLQ_BYTES bytes all with bit 7 set gives an error word.
module midi_track_event_parser
   import mtep_pkg::*;
#(
   parameter int MAX_VLQ_BYTES = 4
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_track_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_event_kind,
   output logic [3:0]          rsp_channel,
   output logic [6:0]          rsp_key,
   output logic [6:0]          rsp_velocity,
   output logic [DELTA_W-1:0]  rsp_delta_ticks,
   output logic [TEMPO_W-1:0]  rsp_tempo_us
);

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   mtep_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_track_start (req_track_start),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop)
   );

   mtep_back #(
      .MAX_VLQ_BYTES (MAX_VLQ_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_channel     (rsp_channel),
      .rsp_key         (rsp_key),
      .rsp_velocity    (rsp_velocity),
      .rsp_delta_ticks (rsp_delta_ticks),
      .rsp_tempo_us    (rsp_tempo_us)
   );

endmodule
